FILE: rtl/core/rss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rss_pkg: shared types and constants for the record stack
// Record layout, request and response payloads, operation codes and sizes.
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 7;
  localparam int DEPTH_W = 7;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_FIND   = 3'd3;
  localparam logic [2:0] OP_DELETE = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  typedef struct packed {
    logic [15:0] number;
    logic [4:0]  dep_h;
    logic [5:0]  dep_m;
    logic [4:0]  arr_h;
    logic [5:0]  arr_m;
    logic [1:0]  circ;
    logic [15:0] dest;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic [2:0]       op;
    logic [15:0]      train_number;
    logic [4:0]       depart_hour;
    logic [5:0]       depart_minute;
    logic [4:0]       arrive_hour;
    logic [5:0]       arrive_minute;
    logic [1:0]       circulation;
    logic [15:0]      destination_ref;
    logic [POS_W-1:0] position;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [15:0]        out_number;
    logic [4:0]         out_depart_hour;
    logic [5:0]         out_depart_minute;
    logic [4:0]         out_arrive_hour;
    logic [5:0]         out_arrive_minute;
    logic [1:0]         out_circulation;
    logic [15:0]        out_destination_ref;
    logic [DEPTH_W-1:0] depth;
  } rsp_t;

endpackage
`default_nettype wire

FILE: rtl/core/record_stack_with_search_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// record_stack_with_search_core: bounded LIFO of train records with search
// Push, pop, read by position, find by number, delete at position, clear.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready, payload req) carries one operation;
//   rsp channel (rsp_valid/rsp_ready, payload rsp) returns exactly one
//   response per operation: ok flag, touched record and depth afterwards.
//   One operation is in flight at a time; req_ready is high only while the
//   sequencer is idle, so a new request is not taken until the previous
//   operation has finished its steps. One RAM read port serves every step.
//   Steps per operation: push, clear and failed operations go straight to
//   the response; pop and read fetch one entry from the RAM; find reads
//   entries from the top down until the number matches or the bottom is
//   reached; delete at position p reads that entry, then moves each entry
//   above it down one place.
//   A stalled receiver holds the response register; the next request is
//   still taken, and its response waits until the register frees.
//   Reset empties the stack at once; RAM contents are left as they are.
// ----------------------------------------------------------------------------
module record_stack_with_search_core
  import rss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RD    = 5'b00010,
    S_FIND  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [ADDR_W-1:0] idx, idx_next;
  req_t              cur;
  logic              res_ok, res_ok_next;
  rec_t              res_rec, res_rec_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  rec_t              ram_wdata, ram_rdata;

  rec_t              rec_in;
  logic [CMP_W-1:0]  cmp_diff;
  logic              pos_valid;
  logic [CNT_W:0]    idx_p1, idx_p2;
  logic              accept, rsp_free;

  assign accept   = req_valid && req_ready;
  assign req_ready = (state == S_IDLE);
  assign rsp_free = !rsp_valid || rsp_ready;

  assign rec_in = '{number: req.train_number, dep_h: req.depart_hour,
                    dep_m: req.depart_minute, arr_h: req.arrive_hour,
                    arr_m: req.arrive_minute, circ: req.circulation,
                    dest: req.destination_ref};

  assign cmp_diff  = CMP_W'(count) - CMP_W'(req.position);
  assign pos_valid = (req.position != '0) && (CMP_W'(req.position) <= CMP_W'(count));
  assign idx_p1    = (CNT_W+1)'(idx) + (CNT_W+1)'(1);
  assign idx_p2    = (CNT_W+1)'(idx) + (CNT_W+1)'(2);

  rss_ram #(.WIDTH(REC_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next   = state;
    count_next   = count;
    idx_next     = idx;
    res_ok_next  = res_ok;
    res_rec_next = res_rec;
    ram_we       = 1'b0;
    ram_waddr    = idx;
    ram_wdata    = ram_rdata;
    ram_raddr    = idx;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          res_ok_next  = 1'b0;
          res_rec_next = '0;
          state_next   = S_DONE;
          case (req.op)
            OP_PUSH: begin
              if (count < CNT_W'(DEPTH)) begin
                ram_we       = 1'b1;
                ram_waddr    = ADDR_W'(count);
                ram_wdata    = rec_in;
                count_next   = count + CNT_W'(1);
                res_ok_next  = 1'b1;
                res_rec_next = rec_in;
              end
            end
            OP_POP: begin
              if (count != '0) begin
                count_next = count - CNT_W'(1);
                ram_raddr  = ADDR_W'(count - CNT_W'(1));
                state_next = S_RD;
              end
            end
            OP_READ: begin
              if (pos_valid) begin
                ram_raddr  = ADDR_W'(cmp_diff);
                state_next = S_RD;
              end
            end
            OP_FIND: begin
              if (count != '0) begin
                ram_raddr  = ADDR_W'(count - CNT_W'(1));
                idx_next   = ADDR_W'(count - CNT_W'(1));
                state_next = S_FIND;
              end
            end
            OP_DELETE: begin
              if (pos_valid) begin
                ram_raddr  = ADDR_W'(cmp_diff);
                idx_next   = ADDR_W'(cmp_diff);
                state_next = S_RD;
              end
            end
            OP_CLEAR: begin
              count_next  = '0;
              res_ok_next = 1'b1;
            end
            default: begin
              res_ok_next = 1'b0;
            end
          endcase
        end
      end
      S_RD: begin
        res_ok_next  = 1'b1;
        res_rec_next = ram_rdata;
        state_next   = S_DONE;
        if (cur.op == OP_DELETE) begin
          if (idx_p1 < (CNT_W+1)'(count)) begin
            ram_raddr  = ADDR_W'(idx_p1);
            state_next = S_SHIFT;
          end else begin
            count_next = count - CNT_W'(1);
          end
        end
      end
      S_SHIFT: begin
        // close the gap: entry above moves down one place
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
        idx_next  = ADDR_W'(idx_p1);
        if (idx_p2 < (CNT_W+1)'(count)) begin
          ram_raddr = ADDR_W'(idx_p2);
        end else begin
          count_next = count - CNT_W'(1);
          state_next = S_DONE;
        end
      end
      S_FIND: begin
        if (ram_rdata.number == cur.train_number) begin
          res_ok_next  = 1'b1;
          res_rec_next = ram_rdata;
          state_next   = S_DONE;
        end else if (idx == '0) begin
          state_next = S_DONE;
        end else begin
          idx_next  = idx - ADDR_W'(1);
          ram_raddr = idx - ADDR_W'(1);
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    res_ok  <= res_ok_next;
    res_rec <= res_rec_next;
    if (accept) begin
      cur <= req;
    end
    if (state == S_DONE && rsp_free) begin
      rsp <= '{ok: res_ok, out_number: res_rec.number,
               out_depart_hour: res_rec.dep_h, out_depart_minute: res_rec.dep_m,
               out_arrive_hour: res_rec.arr_h, out_arrive_minute: res_rec.arr_m,
               out_circulation: res_rec.circ, out_destination_ref: res_rec.dest,
               depth: DEPTH_W'(count)};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && req.op == OP_PUSH && count < CNT_W'(DEPTH))
    |=> count == $past(count) + CNT_W'(1))
    else $error("accepted push did not grow the stack");

  a_find_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND) |-> (count != '0))
    else $error("search running on an empty stack");

  a_shift_ports: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && ram_we && state_next == S_SHIFT) |-> (ram_waddr != ram_raddr))
    else $error("entry move reads and writes the same place");

  a_busy_no_rsp_load: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("held response dropped");

endmodule
`default_nettype wire

FILE: rtl/core/rss_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rss_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
